@@ rtl/kle_pkg.sv @@
// Package for the keystroke line editor: item types, key codes and the control program.
package kle_pkg;

  localparam logic [7:0] KEY_LEFT  = 8'h3C;
  localparam logic [7:0] KEY_RIGHT = 8'h3E;
  localparam logic [7:0] KEY_BACK  = 8'h2D;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       line_end;
  } key_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       empty_line;
  } line_item_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'd0,
    ST_L_RD   = 4'd1,
    ST_L_WR   = 4'd2,
    ST_R_RD   = 4'd3,
    ST_R_WR   = 4'd4,
    ST_BACK   = 4'd5,
    ST_INS    = 4'd6,
    ST_EMPTY  = 4'd7,
    ST_LS_RD  = 4'd8,
    ST_LS_EM  = 4'd9,
    ST_RS_SEL = 4'd10,
    ST_RS_RD  = 4'd11,
    ST_RS_EM  = 4'd12,
    ST_CLR    = 4'd13
  } step_e;

  typedef enum logic [2:0] {
    RD_NONE, RD_LEFT_TOP, RD_RIGHT_TOP, RD_LEFT_IDX, RD_RIGHT_IDX
  } rd_op_e;

  typedef enum logic [1:0] {
    WR_NONE, WR_RIGHT_MOVE, WR_LEFT_MOVE, WR_LEFT_KEY
  } wr_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
  } cnt_op_e;

  typedef enum logic [2:0] {
    IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_LOAD_RC
  } idx_op_e;

  typedef enum logic [1:0] {
    EM_NONE, EM_EMPTY, EM_LEFT, EM_RIGHT
  } em_op_e;

  typedef enum logic [2:0] {
    NX_GOTO, NX_DISPATCH, NX_BR_LEFT, NX_BR_RCZ, NX_BR_IDXZ
  } nx_op_e;

  typedef struct packed {
    logic    accept;
    rd_op_e  rd;
    wr_op_e  wr;
    cnt_op_e lc;
    cnt_op_e rc;
    idx_op_e idx;
    em_op_e  em;
    nx_op_e  nx;
    step_e   target;  // goto target, or branch target when the condition holds
    step_e   alt;     // branch target when the condition fails
  } ucode_t;

  // Control program, one word per step.
  function automatic ucode_t ucode_rom(step_e step);
    ucode_t w;
    w = '{accept: 1'b0, rd: RD_NONE, wr: WR_NONE, lc: CNT_HOLD, rc: CNT_HOLD,
          idx: IDX_HOLD, em: EM_NONE, nx: NX_GOTO, target: ST_IDLE, alt: ST_IDLE};
    case (step)
      ST_IDLE: begin
        w.accept = 1'b1;
        w.idx    = IDX_ZERO;
        w.nx     = NX_DISPATCH;
      end
      ST_L_RD: begin
        w.rd     = RD_LEFT_TOP;
        w.lc     = CNT_DEC;
        w.target = ST_L_WR;
      end
      ST_L_WR: begin
        w.wr = WR_RIGHT_MOVE;
        w.rc = CNT_INC;
      end
      ST_R_RD: begin
        w.rd     = RD_RIGHT_TOP;
        w.rc     = CNT_DEC;
        w.target = ST_R_WR;
      end
      ST_R_WR: begin
        w.wr = WR_LEFT_MOVE;
        w.lc = CNT_INC;
      end
      ST_BACK: w.lc = CNT_DEC;
      ST_INS: begin
        w.wr = WR_LEFT_KEY;
        w.lc = CNT_INC;
      end
      ST_EMPTY: w.em = EM_EMPTY;
      ST_LS_RD: begin
        w.rd     = RD_LEFT_IDX;
        w.target = ST_LS_EM;
      end
      ST_LS_EM: begin
        w.em     = EM_LEFT;
        w.idx    = IDX_INC;
        w.nx     = NX_BR_LEFT;
        w.target = ST_RS_SEL;
        w.alt    = ST_LS_RD;
      end
      ST_RS_SEL: begin
        w.idx    = IDX_LOAD_RC;
        w.nx     = NX_BR_RCZ;
        w.target = ST_CLR;
        w.alt    = ST_RS_RD;
      end
      ST_RS_RD: begin
        w.rd     = RD_RIGHT_IDX;
        w.target = ST_RS_EM;
      end
      ST_RS_EM: begin
        w.em     = EM_RIGHT;
        w.idx    = IDX_DEC;
        w.nx     = NX_BR_IDXZ;
        w.target = ST_CLR;
        w.alt    = ST_RS_RD;
      end
      ST_CLR: begin
        w.lc = CNT_CLR;
        w.rc = CNT_CLR;
      end
      default: w.target = ST_IDLE;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/keystroke_line_editor.sv @@
// Keystroke line editor: a line held as two stacks, run by a small control program.
//
// Input channel (in_valid_i, in_stall_o, in_item_i) takes one keystroke item at a
// time. '<' and '>' move the cursor, '-' deletes before the cursor, any other byte
// is inserted; moves and deletes change nothing at a line edge, and an insert into a
// full line is dropped. An item with line_end set streams the line out on the
// output channel (out_valid_o, out_stall_i, out_item_o) left to right, last set
// on the final character, or as one item with empty_line set; the line is then
// cleared.
// The block takes one item at a time. A move reads the top of one stack and then
// writes it to the other stack. A line end reads each character from a stack
// memory and then loads it into the output register; when the whole line lies
// right of the cursor, a select step comes first. An empty line end loads the
// empty-line item straight into the output register.
// A stalled receiver holds the output register and the program waits at its
// emit step; no item is lost. Reset empties the line and the output register.
module keystroke_line_editor #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  kle_pkg::key_item_t     in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output kle_pkg::line_item_t    out_item_o
);

  localparam int IW = $clog2(LINE_CAPACITY);
  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam logic [CW-1:0] CAP = CW'(LINE_CAPACITY);

  logic [7:0] left_mem  [LINE_CAPACITY];
  logic [7:0] right_mem [LINE_CAPACITY];

  kle_pkg::step_e      upc_q, upc_d;
  kle_pkg::ucode_t     uc;
  logic [CW-1:0]       lc_q, lc_d, rc_q, rc_d;
  logic [IW-1:0]       idx_q, idx_d;
  logic [7:0]          key_q;
  logic [7:0]          left_rd_q, right_rd_q;
  logic                out_valid_q;
  kle_pkg::line_item_t out_q, out_d;
  logic                out_free, hold, run, out_load;
  logic [CW-1:0]       lc_m1, rc_m1, idx_p1;
  logic [CW:0]         total;
  logic                rd_left, rd_right;
  logic [IW-1:0]       rd_left_addr, rd_right_addr;
  logic                wr_left, wr_right;
  logic [7:0]          wr_left_data;

  assign uc       = kle_pkg::ucode_rom(upc_q);
  assign out_free = !out_valid_q || !out_stall_i;
  assign hold     = (uc.em != kle_pkg::EM_NONE) && !out_free;
  assign run      = !hold;
  assign out_load = run && (uc.em != kle_pkg::EM_NONE);

  assign lc_m1  = lc_q - CW'(1);
  assign rc_m1  = rc_q - CW'(1);
  assign idx_p1 = CW'(idx_q) + CW'(1);
  assign total  = {1'b0, lc_q} + {1'b0, rc_q};

  assign in_stall_o  = !uc.accept;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Next step, including the keystroke dispatch in the idle step.
  always_comb begin
    upc_d = upc_q;
    if (run) begin
      case (uc.nx)
        kle_pkg::NX_GOTO:    upc_d = uc.target;
        kle_pkg::NX_BR_LEFT: upc_d = (idx_p1 == lc_q) ? uc.target : uc.alt;
        kle_pkg::NX_BR_RCZ:  upc_d = (rc_q == '0) ? uc.target : uc.alt;
        kle_pkg::NX_BR_IDXZ: upc_d = (idx_q == '0) ? uc.target : uc.alt;
        kle_pkg::NX_DISPATCH: begin
          upc_d = kle_pkg::ST_IDLE;
          if (in_valid_i) begin
            if (in_item_i.line_end) begin
              if (total == '0)      upc_d = kle_pkg::ST_EMPTY;
              else if (lc_q == '0)  upc_d = kle_pkg::ST_RS_SEL;
              else                  upc_d = kle_pkg::ST_LS_RD;
            end else begin
              case (in_item_i.key_byte)
                kle_pkg::KEY_LEFT: begin
                  if (lc_q != '0 && rc_q != CAP) upc_d = kle_pkg::ST_L_RD;
                end
                kle_pkg::KEY_RIGHT: begin
                  if (rc_q != '0 && lc_q != CAP) upc_d = kle_pkg::ST_R_RD;
                end
                kle_pkg::KEY_BACK: begin
                  if (lc_q != '0) upc_d = kle_pkg::ST_BACK;
                end
                default: begin
                  if (total < {1'b0, CAP}) upc_d = kle_pkg::ST_INS;
                end
              endcase
            end
          end
        end
        default: upc_d = kle_pkg::ST_IDLE;
      endcase
    end
  end

  // Counters and the stream index.
  always_comb begin
    lc_d  = lc_q;
    rc_d  = rc_q;
    idx_d = idx_q;
    if (run) begin
      case (uc.lc)
        kle_pkg::CNT_INC: lc_d = lc_q + CW'(1);
        kle_pkg::CNT_DEC: lc_d = lc_m1;
        kle_pkg::CNT_CLR: lc_d = '0;
        default:          lc_d = lc_q;
      endcase
      case (uc.rc)
        kle_pkg::CNT_INC: rc_d = rc_q + CW'(1);
        kle_pkg::CNT_DEC: rc_d = rc_m1;
        kle_pkg::CNT_CLR: rc_d = '0;
        default:          rc_d = rc_q;
      endcase
      case (uc.idx)
        kle_pkg::IDX_ZERO:    idx_d = '0;
        kle_pkg::IDX_INC:     idx_d = idx_q + IW'(1);
        kle_pkg::IDX_DEC:     idx_d = idx_q - IW'(1);
        kle_pkg::IDX_LOAD_RC: idx_d = rc_m1[IW-1:0];
        default:              idx_d = idx_q;
      endcase
    end
  end

  // Memory port controls.
  always_comb begin
    rd_left       = 1'b0;
    rd_right      = 1'b0;
    rd_left_addr  = idx_q;
    rd_right_addr = idx_q;
    case (uc.rd)
      kle_pkg::RD_LEFT_TOP: begin
        rd_left      = 1'b1;
        rd_left_addr = lc_m1[IW-1:0];
      end
      kle_pkg::RD_RIGHT_TOP: begin
        rd_right      = 1'b1;
        rd_right_addr = rc_m1[IW-1:0];
      end
      kle_pkg::RD_LEFT_IDX:  rd_left  = 1'b1;
      kle_pkg::RD_RIGHT_IDX: rd_right = 1'b1;
      default: ;
    endcase
    wr_left      = 1'b0;
    wr_right     = 1'b0;
    wr_left_data = key_q;
    case (uc.wr)
      kle_pkg::WR_RIGHT_MOVE: wr_right = 1'b1;
      kle_pkg::WR_LEFT_MOVE: begin
        wr_left      = 1'b1;
        wr_left_data = right_rd_q;
      end
      kle_pkg::WR_LEFT_KEY: wr_left = 1'b1;
      default: ;
    endcase
  end

  // Result item for the current emit step.
  always_comb begin
    out_d = out_q;
    case (uc.em)
      kle_pkg::EM_EMPTY: out_d = '{out_byte: 8'h00, last: 1'b1, empty_line: 1'b1};
      kle_pkg::EM_LEFT:
        out_d = '{out_byte: left_rd_q, last: (idx_p1 == lc_q) && (rc_q == '0),
                  empty_line: 1'b0};
      kle_pkg::EM_RIGHT:
        out_d = '{out_byte: right_rd_q, last: (idx_q == '0), empty_line: 1'b0};
      default: out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= kle_pkg::ST_IDLE;
      lc_q        <= '0;
      rc_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      lc_q  <= lc_d;
      rc_q  <= rc_d;
      idx_q <= idx_d;
      if (out_load)         out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uc.accept && in_valid_i) key_q <= in_item_i.key_byte;
    if (out_load) out_q <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_left) left_mem[lc_q[IW-1:0]] <= wr_left_data;
    if (rd_left) left_rd_q <= left_mem[rd_left_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_right) right_mem[rc_q[IW-1:0]] <= left_rd_q;
    if (rd_right) right_rd_q <= right_mem[rd_right_addr];
  end

endmodule
